>>> sv/dss_pkg.sv
// shared types and constants for the two-stack shared array
`timescale 1ns / 1ps

package dss_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;

    typedef enum logic [2:0] {
        OP_PUSH_ONE = 3'd0,
        OP_PUSH_TWO = 3'd1,
        OP_POP_ONE  = 3'd2,
        OP_POP_TWO  = 3'd3,
        OP_DUMP_ONE = 3'd4,
        OP_DUMP_TWO = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    push_low;
        logic    push_high;
        logic    pop_low;
        logic    pop_high;
        logic    dump_low;
        logic    dump_high;
        logic    scan_step;
        logic    rd_last;
        logic    emit_now;
        status_t emit_status;
    } dss_cmd_t;

    typedef struct packed {
        logic full;
        logic low_empty;
        logic high_empty;
        logic low_single;
        logic high_single;
        logic scan_end;
    } dss_stat_t;

endpackage

>>> sv/dss_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/dss_ctrl.sv
// controller state machine for the two-stack shared array
`timescale 1ns / 1ps

module dss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        opcode,
    input  dss_pkg::dss_stat_t stat,
    output dss_pkg::dss_cmd_t  cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic         busy_reg;
    logic         busy_next;
    dss_pkg::op_t op;

    assign op   = dss_pkg::op_t'(opcode);
    assign busy = busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        dss_pkg::OP_PUSH_ONE, dss_pkg::OP_PUSH_TWO:
                        begin
                            cmd.emit_now = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = dss_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.emit_status = dss_pkg::ST_OK;
                                cmd.push_low    = (op == dss_pkg::OP_PUSH_ONE);
                                cmd.push_high   = (op == dss_pkg::OP_PUSH_TWO);
                            end
                        end
                        dss_pkg::OP_POP_ONE:
                        begin
                            if (stat.low_empty)
                            begin
                                cmd.emit_now    = 1'b1;
                                cmd.emit_status = dss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_low = 1'b1;
                                cmd.rd_last = 1'b1;
                                state_next  = S_DRAIN;
                            end
                        end
                        dss_pkg::OP_POP_TWO:
                        begin
                            if (stat.high_empty)
                            begin
                                cmd.emit_now    = 1'b1;
                                cmd.emit_status = dss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_high = 1'b1;
                                cmd.rd_last  = 1'b1;
                                state_next   = S_DRAIN;
                            end
                        end
                        dss_pkg::OP_DUMP_ONE:
                        begin
                            if (stat.low_empty)
                            begin
                                cmd.emit_now    = 1'b1;
                                cmd.emit_status = dss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_low = 1'b1;
                                cmd.rd_last  = stat.low_single;
                                state_next   = stat.low_single ? S_DRAIN : S_SCAN;
                            end
                        end
                        dss_pkg::OP_DUMP_TWO:
                        begin
                            if (stat.high_empty)
                            begin
                                cmd.emit_now    = 1'b1;
                                cmd.emit_status = dss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_high = 1'b1;
                                cmd.rd_last   = stat.high_single;
                                state_next    = stat.high_single ? S_DRAIN : S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> sv/dss_datapath.sv
// stack pointers, shared store, dump scan and result registers
`timescale 1ns / 1ps

module dss_datapath #(
    parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dss_pkg::dss_cmd_t          cmd,
    input  logic signed [31:0]        push_value,
    output dss_pkg::dss_stat_t         stat,
    output logic                      result_valid,
    output logic [1:0]                status,
    output logic signed [31:0]        word_out,
    output logic                      last_of_run
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_low_reg;
    logic [CW-1:0] count_low_next;
    logic [CW-1:0] base_high_reg;
    logic [CW-1:0] base_high_next;
    logic [AW-1:0] scan_reg;
    logic [AW-1:0] scan_next;
    logic          down_reg;
    logic          down_next;
    logic          rd_valid_reg;
    logic          rd_last_reg;
    logic          result_valid_reg;
    logic          result_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [31:0]   word_reg;
    logic [31:0]   word_next;
    logic          last_reg;
    logic          last_next;

    logic [CW-1:0] low_m1;
    logic [CW-1:0] low_m2;
    logic [CW-1:0] high_m1;
    logic [CW-1:0] high_p1;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    assign low_m1  = count_low_reg - CW'(1);
    assign low_m2  = count_low_reg - CW'(2);
    assign high_m1 = base_high_reg - CW'(1);
    assign high_p1 = base_high_reg + CW'(1);

    assign stat.full        = (count_low_reg == base_high_reg);
    assign stat.low_empty   = (count_low_reg == '0);
    assign stat.high_empty  = (base_high_reg == CW'(DEPTH));
    assign stat.low_single  = (count_low_reg == CW'(1));
    assign stat.high_single = (base_high_reg == CW'(DEPTH - 1));
    assign stat.scan_end    = down_reg ? (scan_reg == '0) : (scan_reg == AW'(DEPTH - 1));

    assign wr_en   = cmd.push_low | cmd.push_high;
    assign wr_addr = cmd.push_low ? count_low_reg[AW-1:0] : high_m1[AW-1:0];
    assign rd_en   = cmd.pop_low | cmd.pop_high | cmd.dump_low | cmd.dump_high
                   | cmd.scan_step;

    always_comb
    begin
        if (cmd.pop_low || cmd.dump_low)
        begin
            rd_addr = low_m1[AW-1:0];
        end
        else if (cmd.pop_high || cmd.dump_high)
        begin
            rd_addr = base_high_reg[AW-1:0];
        end
        else
        begin
            rd_addr = scan_reg;
        end
    end

    always_comb
    begin
        count_low_next = count_low_reg;
        base_high_next = base_high_reg;
        scan_next      = scan_reg;
        down_next      = down_reg;
        if (cmd.push_low)
        begin
            count_low_next = count_low_reg + CW'(1);
        end
        if (cmd.pop_low)
        begin
            count_low_next = low_m1;
        end
        if (cmd.push_high)
        begin
            base_high_next = high_m1;
        end
        if (cmd.pop_high)
        begin
            base_high_next = high_p1;
        end
        if (cmd.dump_low)
        begin
            scan_next = low_m2[AW-1:0];
            down_next = 1'b1;
        end
        if (cmd.dump_high)
        begin
            scan_next = high_p1[AW-1:0];
            down_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            scan_next = down_reg ? scan_reg - AW'(1) : scan_reg + AW'(1);
        end
    end

    always_comb
    begin
        result_valid_next = 1'b0;
        status_next       = status_reg;
        word_next         = word_reg;
        last_next         = last_reg;
        if (rd_valid_reg)
        begin
            result_valid_next = 1'b1;
            status_next       = dss_pkg::ST_OK;
            word_next         = rd_data;
            last_next         = rd_last_reg;
        end
        else if (cmd.emit_now)
        begin
            result_valid_next = 1'b1;
            status_next       = cmd.emit_status;
            word_next         = '0;
            last_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_low_reg    <= '0;
            base_high_reg    <= CW'(DEPTH);
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_low_reg    <= count_low_next;
            base_high_reg    <= base_high_next;
            rd_valid_reg     <= rd_en;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        down_reg    <= down_next;
        rd_last_reg <= cmd.rd_last;
        status_reg  <= status_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
    end

    dss_ram #(
        .WIDTH (dss_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign word_out     = word_reg;
    assign last_of_run  = last_reg;

endmodule

>>> sv/dual_stack_shared_array.sv
// top level of two lifo stacks sharing one store
//
// channel   signals                                  transaction
// command   start, busy, opcode, push_value          start high while busy low
// result    result_valid, status, word_out,          one cycle per result,
//           last_of_run                              no back-pressure
//
// push and full or empty results: busy stays low, result in the next cycle,
// so pushes run one per cycle
// pop: busy for one cycle while the store read completes, result via the read data register
// dump of n words: busy until the last store read completes, one word per cycle from the store read port
// reset: both stacks empty; the store itself is not cleared
`timescale 1ns / 1ps

module dual_stack_shared_array #(
    parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] push_value,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic signed [31:0] word_out,
    output logic               last_of_run
);

    dss_pkg::dss_cmd_t  cmd;
    dss_pkg::dss_stat_t stat;

    dss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    dss_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .push_value   (push_value),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .word_out     (word_out),
        .last_of_run  (last_of_run)
    );

`ifndef ASSERT_OFF
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == dss_pkg::OP_PUSH_ONE || opcode == dss_pkg::OP_PUSH_TWO)
        |=> result_valid && last_of_run)
        else $error("push transaction without a result");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != dss_pkg::ST_OK |-> last_of_run && word_out == '0)
        else $error("error result not final or carries a word");

    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last_of_run)
        else $error("busy dropped without a final result");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !busy && !result_valid)
        else $error("busy or result during reset");
`endif

endmodule

>>> sim/tb_dual_stack_shared_array.sv
// testbench for the two-stack shared array: directed and random commands vs a predictor
`timescale 1ns / 1ps

module tb_dual_stack_shared_array;

    localparam int DEPTH       = dss_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

    localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;

    typedef struct {
        dss_pkg::status_t status;
        logic [31:0]      word;
        logic             last;
    } stack_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         opcode = '0;
    logic signed [31:0] push_value = '0;
    logic               result_valid;
    logic [1:0]         status;
    logic signed [31:0] word_out;
    logic               last_of_run;

    // predictor state
    logic [31:0] stack_words [DEPTH];
    int          low_count  = 0;
    int          high_base  = DEPTH;

    stack_result_t pending_results[$];

    int sender_idle_pct = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int refused_pushes  = 0;
    int empty_results   = 0;
    int dumped_words    = 0;

    dual_stack_shared_array #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .push_value(push_value),
        .result_valid(result_valid),
        .status(status),
        .word_out(word_out),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void queue_result(dss_pkg::status_t st, logic [31:0] word, logic last);
        stack_result_t r;
        r.status = st;
        r.word   = word;
        r.last   = last;
        pending_results.push_back(r);
        if (st == dss_pkg::ST_FULL)
            refused_pushes++;
        if (st == dss_pkg::ST_EMPTY)
            empty_results++;
    endfunction

    function automatic void predict_stack_op(logic [2:0] op, logic [31:0] val);
        bit full_now;
        full_now = (low_count >= high_base);
        case (op)
            dss_pkg::OP_PUSH_ONE:
            begin
                if (full_now)
                    queue_result(dss_pkg::ST_FULL, '0, 1'b1);
                else
                begin
                    stack_words[low_count] = val;
                    low_count++;
                    queue_result(dss_pkg::ST_OK, '0, 1'b1);
                end
            end
            dss_pkg::OP_PUSH_TWO:
            begin
                if (full_now)
                    queue_result(dss_pkg::ST_FULL, '0, 1'b1);
                else
                begin
                    high_base--;
                    stack_words[high_base] = val;
                    queue_result(dss_pkg::ST_OK, '0, 1'b1);
                end
            end
            dss_pkg::OP_POP_ONE:
            begin
                if (low_count == 0)
                    queue_result(dss_pkg::ST_EMPTY, '0, 1'b1);
                else
                begin
                    low_count--;
                    queue_result(dss_pkg::ST_OK, stack_words[low_count], 1'b1);
                end
            end
            dss_pkg::OP_POP_TWO:
            begin
                if (high_base >= DEPTH)
                    queue_result(dss_pkg::ST_EMPTY, '0, 1'b1);
                else
                begin
                    queue_result(dss_pkg::ST_OK, stack_words[high_base], 1'b1);
                    high_base++;
                end
            end
            dss_pkg::OP_DUMP_ONE:
            begin
                if (low_count == 0)
                    queue_result(dss_pkg::ST_EMPTY, '0, 1'b1);
                else
                    for (int i = low_count - 1; i >= 0; i--)
                    begin
                        queue_result(dss_pkg::ST_OK, stack_words[i], i == 0);
                        dumped_words++;
                    end
            end
            dss_pkg::OP_DUMP_TWO:
            begin
                if (high_base >= DEPTH)
                    queue_result(dss_pkg::ST_EMPTY, '0, 1'b1);
                else
                    for (int i = high_base; i < DEPTH; i++)
                    begin
                        queue_result(dss_pkg::ST_OK, stack_words[i], i == DEPTH - 1);
                        dumped_words++;
                    end
            end
            default:
            begin
                // spare opcodes leave the stacks alone and answer nothing
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input stack_result_t exp_r);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s: expected status %0d word %h last %0b, %s %0d word %h last %0b",
                     $time, what, exp_r.status, exp_r.word, exp_r.last,
                     "got status", status, word_out, last_of_run);
    endtask

    always @(posedge clk)
    begin : result_check
        stack_result_t exp_r;
        if (rst_n && result_valid)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                exp_r.status = dss_pkg::ST_OK;
                exp_r.word   = '0;
                exp_r.last   = 1'b0;
                report_mismatch("result with nothing pending", exp_r);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status || word_out !== exp_r.word
                    || last_of_run !== exp_r.last)
                    report_mismatch("result mismatch", exp_r);
            end
        end
    end

    // leaves start high after the transaction so back-to-back commands need no gap
    task automatic send_command(input logic [2:0] op, input logic [31:0] val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        push_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_stack_op(op, val);
        if (op <= dss_pkg::OP_DUMP_TWO)
            commands_sent++;
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_stacks();
        send_command(dss_pkg::OP_POP_ONE, $urandom);
        send_command(dss_pkg::OP_POP_TWO, $urandom);
        send_command(dss_pkg::OP_DUMP_ONE, $urandom);
        send_command(dss_pkg::OP_DUMP_TWO, $urandom);
        pause_until_drained();
    endtask

    task automatic test_fill_until_full();
        logic [31:0] val;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       val = 32'h7fff_ffff;
                1:       val = 32'h8000_0000;
                2:       val = 32'h0000_0000;
                3:       val = 32'hffff_ffff;
                default: val = $urandom;
            endcase
            send_command((i % 3 == 2) ? dss_pkg::OP_PUSH_TWO : dss_pkg::OP_PUSH_ONE, val);
        end
        pause_until_drained();
    endtask

    task automatic test_push_refused();
        send_command(dss_pkg::OP_PUSH_ONE, $urandom);
        send_command(dss_pkg::OP_PUSH_TWO, $urandom);
        pause_until_drained();
    endtask

    task automatic test_dump_both();
        send_command(dss_pkg::OP_DUMP_ONE, $urandom);
        send_command(dss_pkg::OP_DUMP_TWO, $urandom);
        pause_until_drained();
    endtask

    task automatic test_pop_both();
        send_command(dss_pkg::OP_POP_ONE, $urandom);
        send_command(dss_pkg::OP_POP_TWO, $urandom);
        pause_until_drained();
    endtask

    task automatic test_spare_opcodes();
        send_command(OP_SPARE_SIX, $urandom);
        send_command(OP_SPARE_SEVEN, $urandom);
        pause_until_drained();
    endtask

    // alternates between filling and draining so both full and empty stacks come up often
    task automatic test_random_mix(input int n_commands);
        int  sent;
        int  pick;
        bit  draining;
        sent     = 0;
        draining = 1'b0;
        while (sent < n_commands)
        begin
            if ($urandom_range(24) == 0)
                draining = ~draining;
            if ($urandom_range(39) == 0)
                pause_until_drained();
            pick = $urandom_range(99);
            if (pick >= 95)
                send_command(($urandom_range(1) == 1) ? OP_SPARE_SEVEN : OP_SPARE_SIX, $urandom);
            else
            begin
                if (pick >= 80)
                    send_command((pick >= 88) ? dss_pkg::OP_DUMP_TWO : dss_pkg::OP_DUMP_ONE,
                                 $urandom);
                else if (pick < (draining ? 15 : 50))
                    send_command((pick % 2 == 1) ? dss_pkg::OP_PUSH_TWO : dss_pkg::OP_PUSH_ONE,
                                 pick_word());
                else
                    send_command((pick % 2 == 1) ? dss_pkg::OP_POP_TWO : dss_pkg::OP_POP_ONE,
                                 $urandom);
                sent++;
            end
        end
        pause_until_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 12;
        test_empty_stacks();
        test_fill_until_full();
        test_push_refused();
        test_dump_both();
        test_pop_both();
        test_spare_opcodes();
        test_random_mix(60);

        sender_idle_pct = 72;
        test_random_mix(60);

        sender_idle_pct = 0;
        test_random_mix(60);

        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            error_count += pending_results.size();
        end

        $display("ran %0d stack commands plus spare opcodes under three sender idle rates",
                 commands_sent);
        $display("checked %0d results: %0d refused pushes, %0d empty answers, %0d dumped words",
                 results_checked, refused_pushes, empty_results, dumped_words);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
